// File: design/bfrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_pkg
// Shared types and constants for the box filter rgb downsampler.
// ----------------------------------------------------------------------------
package bfrd_pkg;

    // pixel layout
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int RED_LSB     = 16;
    localparam int GREEN_LSB   = 8;
    localparam int BLUE_LSB    = 0;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int SS_REG_W    = 4;
    localparam int DIM_REG_W   = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SS_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd2;

    localparam logic [SS_REG_W-1:0]  SS_RESET     = 4'd2;
    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 11'd768;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic update;
        logic divide;
        logic load_out;
    } bfrd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic emit;
    } bfrd_sts_t;

endpackage
`default_nettype wire

// File: design/bfrd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: design/bfrd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_datapath
// Configuration registers, position counters, column sum store, reciprocal
// divider and output register of the downsampler.
// ----------------------------------------------------------------------------
module bfrd_datapath #(
    parameter int MAX_OUT_WIDTH  = 1024,
    parameter int MAX_OUT_HEIGHT = 1024,
    parameter int MAX_SS         = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr,
    input  wire logic [bfrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bfrd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [bfrd_pkg::PIX_W-1:0]        sample_rgb,
    input  wire bfrd_pkg::bfrd_cmd_t               cmd,
    output bfrd_pkg::bfrd_sts_t                    sts,
    output logic      [bfrd_pkg::PIX_W-1:0]        out_pixel,
    output logic                                   frame_last
);

    localparam int CH_W    = bfrd_pkg::CH_W;
    localparam int COL_W   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int ROW_W   = (MAX_OUT_HEIGHT > 1) ? $clog2(MAX_OUT_HEIGHT) : 1;
    localparam int SS_W    = (MAX_SS > 1) ? $clog2(MAX_SS) : 1;
    localparam int LOG_SS  = $clog2(MAX_SS);
    localparam int SSC_W   = (SS_W + 1 > bfrd_pkg::SS_REG_W + 1) ? SS_W + 1
                                                                 : bfrd_pkg::SS_REG_W + 1;
    localparam int DIM_A   = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
    localparam int DIM_W   = (DIM_A > bfrd_pkg::DIM_REG_W + 1) ? DIM_A
                                                               : bfrd_pkg::DIM_REG_W + 1;
    localparam int SUM_W   = CH_W + 2 * LOG_SS;
    localparam int SHIFT_K = SUM_W + 2 * LOG_SS;
    localparam int RCP_W   = SHIFT_K + 1;
    localparam int PROD_W  = SUM_W + RCP_W;
    localparam int RAM_W   = 3 * SUM_W;

    // configuration registers
    logic [bfrd_pkg::SS_REG_W-1:0]  ss_reg;
    logic [bfrd_pkg::DIM_REG_W-1:0] width_reg;
    logic [bfrd_pkg::DIM_REG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg     <= bfrd_pkg::SS_RESET;
            width_reg  <= bfrd_pkg::WIDTH_RESET;
            height_reg <= bfrd_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                bfrd_pkg::CFG_SS_FACTOR:  ss_reg     <= cfg_data[bfrd_pkg::SS_REG_W-1:0];
                bfrd_pkg::CFG_OUT_WIDTH:  width_reg  <= cfg_data[bfrd_pkg::DIM_REG_W-1:0];
                bfrd_pkg::CFG_OUT_HEIGHT: height_reg <= cfg_data[bfrd_pkg::DIM_REG_W-1:0];
                default:                  ;
            endcase
        end
    end

    // clamped effective settings
    logic [SSC_W-1:0] ss_ext;
    logic [SSC_W-1:0] ss_eff;
    logic [DIM_W-1:0] w_ext;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_ext;
    logic [DIM_W-1:0] h_eff;

    always_comb
    begin
        ss_ext = SSC_W'(ss_reg);
        w_ext  = DIM_W'(width_reg);
        h_ext  = DIM_W'(height_reg);

        if (ss_ext == '0)
            ss_eff = SSC_W'(1);
        else if (ss_ext > SSC_W'(MAX_SS))
            ss_eff = SSC_W'(MAX_SS);
        else
            ss_eff = ss_ext;

        if (w_ext == '0)
            w_eff = DIM_W'(1);
        else if (w_ext > DIM_W'(MAX_OUT_WIDTH))
            w_eff = DIM_W'(MAX_OUT_WIDTH);
        else
            w_eff = w_ext;

        if (h_ext == '0)
            h_eff = DIM_W'(1);
        else if (h_ext > DIM_W'(MAX_OUT_HEIGHT))
            h_eff = DIM_W'(MAX_OUT_HEIGHT);
        else
            h_eff = h_ext;
    end

    // position counters
    logic [SS_W-1:0]  sub_col_reg, sub_col_next;
    logic [SS_W-1:0]  sub_row_reg, sub_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             last_sc, last_sr, last_oc, last_or;

    always_comb
    begin
        last_sc = (SSC_W'(sub_col_reg) + SSC_W'(1)) >= ss_eff;
        last_sr = (SSC_W'(sub_row_reg) + SSC_W'(1)) >= ss_eff;
        last_oc = (DIM_W'(out_col_reg) + DIM_W'(1)) >= w_eff;
        last_or = (DIM_W'(out_row_reg) + DIM_W'(1)) >= h_eff;

        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (!last_sc)
            sub_col_next = sub_col_reg + SS_W'(1);
        else
        begin
            sub_col_next = '0;
            if (!last_oc)
                out_col_next = out_col_reg + COL_W'(1);
            else
            begin
                out_col_next = '0;
                if (!last_sr)
                    sub_row_next = sub_row_reg + SS_W'(1);
                else
                begin
                    sub_row_next = '0;
                    if (!last_or)
                        out_row_next = out_row_reg + ROW_W'(1);
                    else
                        out_row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // latched item on transfer
    logic [bfrd_pkg::PIX_W-1:0] sample_reg;
    logic [COL_W-1:0]           col_reg;
    logic                       first_reg;
    logic                       emit_reg;
    logic                       last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            emit_reg <= last_sc && last_sr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_rgb;
            col_reg    <= out_col_reg;
            first_reg  <= (sub_row_reg == '0) && (sub_col_reg == '0);
            last_reg   <= last_oc && last_or;
        end
    end

    // clearing sweep address
    logic [COL_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_step)
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
    end

    // column sum store
    logic             ram_we;
    logic [COL_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic [SUM_W-1:0] new_r, new_g, new_b;

    always_comb
    begin
        if (first_reg)
        begin
            new_r = SUM_W'(sample_reg[bfrd_pkg::RED_LSB +: CH_W]);
            new_g = SUM_W'(sample_reg[bfrd_pkg::GREEN_LSB +: CH_W]);
            new_b = SUM_W'(sample_reg[bfrd_pkg::BLUE_LSB +: CH_W]);
        end
        else
        begin
            new_r = ram_rdata[2*SUM_W +: SUM_W] + SUM_W'(sample_reg[bfrd_pkg::RED_LSB +: CH_W]);
            new_g = ram_rdata[SUM_W +: SUM_W] + SUM_W'(sample_reg[bfrd_pkg::GREEN_LSB +: CH_W]);
            new_b = ram_rdata[0 +: SUM_W] + SUM_W'(sample_reg[bfrd_pkg::BLUE_LSB +: CH_W]);
        end

        ram_we    = cmd.clear_step || cmd.update;
        ram_waddr = cmd.clear_step ? clr_addr_reg : col_reg;
        ram_wdata = cmd.clear_step ? '0 : {new_r, new_g, new_b};
    end

    bfrd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_sum_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.accept),
        .rd_addr (out_col_reg),
        .rd_data (ram_rdata)
    );

    // block sums held for the divider
    logic [SUM_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            sum_r_reg <= new_r;
            sum_g_reg <= new_g;
            sum_b_reg <= new_b;
        end
    end

    // reciprocal of the block area, one entry per factor
    logic [RCP_W-1:0] recip_tab [MAX_SS];

    for (genvar i = 0; i < MAX_SS; i++)
    begin : g_recip
        localparam longint AREA  = (i + 1) * (i + 1);
        localparam longint RECIP = ((64'd1 << SHIFT_K) + AREA - 1) / AREA;
        assign recip_tab[i] = RCP_W'(RECIP);
    end

    logic [RCP_W-1:0] recip_sel;
    logic [SS_W-1:0]  recip_idx;

    assign recip_idx = SS_W'(ss_eff - SSC_W'(1));
    assign recip_sel = recip_tab[recip_idx];

    // division by the area as multiplication by its reciprocal
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.divide)
        begin
            prod_r_reg <= {{RCP_W{1'b0}}, sum_r_reg} * {{SUM_W{1'b0}}, recip_sel};
            prod_g_reg <= {{RCP_W{1'b0}}, sum_g_reg} * {{SUM_W{1'b0}}, recip_sel};
            prod_b_reg <= {{RCP_W{1'b0}}, sum_b_reg} * {{SUM_W{1'b0}}, recip_sel};
        end
    end

    // output register
    logic [bfrd_pkg::PIX_W-1:0] out_pixel_reg;
    logic                       frame_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pixel_reg  <= {prod_r_reg[SHIFT_K +: CH_W],
                               prod_g_reg[SHIFT_K +: CH_W],
                               prod_b_reg[SHIFT_K +: CH_W]};
            frame_last_reg <= last_reg;
        end
    end

    assign out_pixel      = out_pixel_reg;
    assign frame_last     = frame_last_reg;
    assign sts.clear_last = (clr_addr_reg == COL_W'(MAX_OUT_WIDTH - 1));
    assign sts.emit       = emit_reg;

endmodule
`default_nettype wire

// File: design/bfrd_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_controller
// Sequencer for the clearing sweep, the sum update and the output handoff.
// ----------------------------------------------------------------------------
module bfrd_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire bfrd_pkg::bfrd_sts_t  sts,
    output bfrd_pkg::bfrd_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        can_load   = !out_valid_reg || out_ready;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.update = 1'b1;
                state_next = sts.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.divide = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.load_out = can_load;
                if (can_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: design/box_filter_rgb_downsampler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_rgb_downsampler_core
// Box filter resolve of a supersampled rgb stream to one pixel per block.
// ----------------------------------------------------------------------------
// After reset the column sum store is swept to zero, one entry per cycle;
// in_ready stays low during the sweep while configuration writes are taken at
// any time. Then each sample passes the accept and update states, and a sample
// that closes an ss-by-ss block also passes the divide and output states,
// waiting there while the output register is full and out_ready is low. The
// steps follow from the read-modify-write of the column sums through the
// registered RAM read and the reciprocal multiply for the area division. A
// finished pixel waits in the output register as the next samples are taken.
// ----------------------------------------------------------------------------
module box_filter_rgb_downsampler_core #(
    parameter int MAX_OUT_WIDTH  = 1024,
    parameter int MAX_OUT_HEIGHT = 1024,
    parameter int MAX_SS         = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bfrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bfrd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [bfrd_pkg::PIX_W-1:0]       sample_rgb,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [bfrd_pkg::PIX_W-1:0]       out_pixel,
    output logic                                  frame_last
);

    bfrd_pkg::bfrd_cmd_t cmd;
    bfrd_pkg::bfrd_sts_t sts;
    logic                cfg_wr;

    // configuration transfers are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    bfrd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfrd_datapath #(
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT),
        .MAX_SS         (MAX_SS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_rgb (sample_rgb),
        .cmd        (cmd),
        .sts        (sts),
        .out_pixel  (out_pixel),
        .frame_last (frame_last)
    );

endmodule
`default_nettype wire
